/* sv/dsrs_pkg.sv */
// ----------------------------------------------------------------------------
// dsrs_pkg
// Shared types and constants of the descending score rank sorter.
// ----------------------------------------------------------------------------
package dsrs_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 6;
  localparam int REC_W       = SCORE_W + TAG_W;
  localparam int DATA_W      = ((REC_W + 7) / 8) * 8;

  // Score in the low bits, tag above it.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } rec_t;

  // Request from the sequencer to the record memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // Tells the result stage to capture the memory read data.
  typedef struct packed {
    logic cap;
    logic last;
    logic ovf;
  } emit_t;

endpackage

/* sv/dsrs_ram.sv */
// ----------------------------------------------------------------------------
// dsrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dsrs_ctrl.sv */
// ----------------------------------------------------------------------------
// dsrs_ctrl
// Sequencer: loads records, runs the exchange sort in memory, reads out ranks.
// ----------------------------------------------------------------------------
module dsrs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dsrs_pkg::rec_t                in_rec,
  input  logic                          in_last,
  output dsrs_pkg::ram_req_t            ram_req,
  input  dsrs_pkg::rec_t                rd_data,
  input  logic                          out_free,
  output dsrs_pkg::emit_t               emit
);
  import dsrs_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD     = 7'b0000001,
    S_FETCH    = 7'b0000010,
    S_GRAB     = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_PUT      = 7'b0010000,
    S_EMIT_RD  = 7'b0100000,
    S_EMIT_CAP = 7'b1000000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             dropped;
  logic [IDX_W-1:0] a_idx;
  logic [CNT_W-1:0] b_cnt;
  logic [IDX_W-1:0] p_idx;
  logic [IDX_W-1:0] k_idx;
  rec_t             cur;

  logic             accept;
  logic             has_room;
  logic             swap;
  logic [IDX_W-1:0] last_idx;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign has_room = (count < CNT_W'(MAX_RECORDS));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  // The held record never swaps with its own stale slot.
  assign swap     = (state == S_SCAN) && (p_idx != a_idx) && (cur.score > rd_data.score);

  always_comb begin
    ram_req       = '0;
    emit.cap      = (state == S_EMIT_CAP);
    emit.last     = (k_idx == last_idx);
    emit.ovf      = dropped;
    case (state)
      S_LOAD: begin
        ram_req.we    = accept && has_room;
        ram_req.waddr = count[IDX_W-1:0];
        ram_req.wdata = in_rec;
      end
      S_FETCH: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = a_idx;
      end
      S_GRAB: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
      end
      S_SCAN: begin
        ram_req.we    = swap;
        ram_req.waddr = p_idx;
        ram_req.wdata = cur;
        ram_req.re    = (b_cnt != count);
        ram_req.raddr = b_cnt[IDX_W-1:0];
      end
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = a_idx;
        ram_req.wdata = cur;
      end
      S_EMIT_RD: begin
        ram_req.re    = out_free;
        ram_req.raddr = k_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      a_idx   <= '0;
      b_cnt   <= '0;
      p_idx   <= '0;
      k_idx   <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_last) begin
              a_idx <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_GRAB;
        end
        S_GRAB: begin
          p_idx <= '0;
          b_cnt <= CNT_W'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          p_idx <= b_cnt[IDX_W-1:0];
          b_cnt <= b_cnt + CNT_W'(1);
          if (b_cnt == count) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (a_idx == last_idx) begin
            k_idx <= '0;
            state <= S_EMIT_RD;
          end else begin
            a_idx <= a_idx + IDX_W'(1);
            state <= S_FETCH;
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state <= S_EMIT_CAP;
          end
        end
        S_EMIT_CAP: begin
          k_idx <= k_idx + IDX_W'(1);
          if (k_idx == last_idx) begin
            count   <= '0;
            dropped <= 1'b0;
            state   <= S_LOAD;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Held record of the outer pass; take the displaced one on a swap.
  always_ff @(posedge clk) begin
    if (state == S_GRAB || swap) begin
      cur <= rd_data;
    end
  end

endmodule

/* sv/descending_score_rank_sort.sv */
// ----------------------------------------------------------------------------
// descending_score_rank_sort
// Collects scored records, exchange-sorts them in place, emits them by rank.
// ----------------------------------------------------------------------------
// Load: one record per cycle, stored in arrival order in a single RAM.
// Sort: starts on the record with tlast and runs one compare per cycle on the
//   RAM read port.
// Emit: each result is read from the RAM, then captured into the output
//   register, one at a time, while the sink keeps up. Input stalls until
//   the last result has been captured.
// Reset (rst, synchronous, active high) clears the sequencer, the record
//   count, the drop mark and the output valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module descending_score_rank_sort (
  input  logic                        clk,
  input  logic                        rst,
  // Records in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dsrs_pkg::DATA_W-1:0] s_axis_tdata,  // score_key[31:0], record_tag[37:32]
  input  logic                        s_axis_tlast,  // last_item
  // Ranked records out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dsrs_pkg::DATA_W-1:0] m_axis_tdata,  // sorted_score[31:0], sorted_tag[37:32]
  output logic                        m_axis_tlast,  // end_of_run
  output logic                        m_axis_tuser   // overflow_flag
);
  import dsrs_pkg::*;

  ram_req_t ram_req;
  rec_t     in_rec;
  rec_t     rd_data;
  emit_t    emit;
  logic     out_free;

  rec_t     out_rec;
  logic     out_last;
  logic     out_ovf;

  // Unpack the request payload; pad bits above the tag are ignored.
  assign in_rec = rec_t'(s_axis_tdata[REC_W-1:0]);

  // The output register can take a new result if it is empty or
  // is being drained in this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  dsrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_rec   (in_rec),
    .in_last  (s_axis_tlast),
    .ram_req  (ram_req),
    .rd_data  (rd_data),
    .out_free (out_free),
    .emit     (emit)
  );

  // Record store: score and tag side by side in one word.
  dsrs_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // Result stage: hold a ranked record until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.cap) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.cap) begin
      out_rec  <= rd_data;
      out_last <= emit.last;
      out_ovf  <= emit.ovf;
    end
  end

  assign m_axis_tdata = {(DATA_W - REC_W)'(0), out_rec};
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_ovf;

endmodule
